// File: rtl/lhrt_pkg.sv
// lhrt_pkg: shared types, constants and codes of the layered hash rule table
// used by lhrt_ctrl, lhrt_dp and layered_hash_rule_table_top; depends on nothing

package lhrt_pkg;

	// table geometry and field widths
	localparam int WAYS_DEF        = 8;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int BUCKETS         = 256;
	localparam int BUCKET_W        = 8;
	localparam int KEY_W           = 64;
	localparam int HANDLE_W        = 16;
	localparam int LAYER_W         = 3;
	localparam int LIU_W           = 4;
	localparam int CMD_W           = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// request payload
	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	// response payload
	typedef struct packed {
		logic                status;
		logic                hit;
		logic [HANDLE_W-1:0] result_handle;
		logic [LAYER_W-1:0]  layer;
		logic [LIU_W-1:0]    layers_in_use;
	} rsp_t;

	// controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic commit;
	} ctrl_cmd_t;

endpackage

// File: rtl/layered_hash_rule_table_top.sv
// layered_hash_rule_table_top: top level of the layered hash rule table
// depends on lhrt_pkg, lhrt_ctrl and lhrt_dp

// The table holds WAYS layers of 256 buckets; a key's low byte picks its
// bucket. Each request (insert, lookup or clear) is taken in an accept
// cycle that reads every layer bank and the bucket fill count at once; the
// EXEC state then compares the keys, writes back and loads the result
// register. A request is taken while the previous result still waits in
// the result register, and a stalled result holds the next request in the
// EXEC state. Clear takes effect in one request, with no sweep of the
// memories. The fallback handle may be written only while no request is in
// flight.

module layered_hash_rule_table_top #(
	parameter int WAYS        = lhrt_pkg::WAYS_DEF,
	parameter int HANDLE_BITS = lhrt_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  lhrt_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output lhrt_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [lhrt_pkg::HANDLE_W-1:0] cfg_wdata
);

	lhrt_pkg::ctrl_cmd_t cmd;

	// sequencer
	lhrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// table datapath
	lhrt_dp #(
		.WAYS        (WAYS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

// File: rtl/lhrt_ctrl.sv
// lhrt_ctrl: two-state sequencer of the layered hash rule table
// depends on lhrt_pkg; drives lhrt_dp through lhrt_pkg::ctrl_cmd_t

module lhrt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output lhrt_pkg::ctrl_cmd_t   cmd
);

	lhrt_pkg::state_t state_q;
	lhrt_pkg::state_t state_d;
	logic             rsp_valid_q;
	logic             slot_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result slot is free when empty or being drained this cycle
	assign slot_free = !rsp_valid_q || rsp_ready;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			lhrt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = lhrt_pkg::ST_EXEC;
				end
			end
			lhrt_pkg::ST_EXEC: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = lhrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lhrt_pkg::ST_IDLE;
			end
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef ASSERT_OFF
	// a commit only lands where the result slot can take it
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> slot_free)
		else $error("commit while result slot occupied");

	// no new request is taken while an accepted request is in flight
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !req_ready)
		else $error("request taken while a request is in flight");

	// a commit always raises the result valid flag
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("commit without result valid");
`endif

endmodule

// File: rtl/lhrt_dp.sv
// lhrt_dp: datapath of the layered hash rule table: layer banks, bucket fill
// counts, compare, write back and result register; depends on lhrt_pkg

module lhrt_dp #(
	parameter int WAYS        = lhrt_pkg::WAYS_DEF,
	parameter int HANDLE_BITS = lhrt_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lhrt_pkg::ctrl_cmd_t           cmd,
	input  lhrt_pkg::req_t                req,
	input  logic                          cfg_we,
	input  logic [lhrt_pkg::HANDLE_W-1:0] cfg_wdata,
	output lhrt_pkg::rsp_t                rsp
);

	localparam int LW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CW = $clog2(WAYS + 1);

	lhrt_pkg::req_t                  req_q;
	lhrt_pkg::rsp_t                  rsp_q;
	lhrt_pkg::rsp_t                  rsp_d;
	logic [lhrt_pkg::HANDLE_W-1:0]   fallback_q;
	logic [CW-1:0]                   layer_cnt_q;
	logic [CW-1:0]                   layer_cnt_d;
	logic [lhrt_pkg::BUCKETS-1:0]    row_valid_q;
	logic [CW-1:0]                   cnt_mem [lhrt_pkg::BUCKETS];
	logic [CW-1:0]                   cnt_rd_q;
	logic [lhrt_pkg::KEY_W-1:0]      key_rd_q [WAYS];
	logic [HANDLE_BITS-1:0]          hdl_rd_q [WAYS];
	logic [lhrt_pkg::BUCKET_W-1:0]   bucket;
	logic [CW-1:0]                   fill;
	logic                            full;
	logic                            is_insert;
	logic                            ins_ok;
	logic [WAYS-1:0]                 match;
	logic                            hit_any;
	logic [LW-1:0]                   hit_idx;
	logic [31:0]                     hdl_ext;
	logic [31:0]                     hdl_kept;
	logic [31:0]                     hit_hdl;
	logic [31:0]                     fill_ext;
	logic [31:0]                     hit_idx_ext;
	logic [31:0]                     cnt_new_ext;
	logic [31:0]                     cnt_cur_ext;

	// fallback handle register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= '0;
		end else if (cfg_we) begin
			fallback_q <= cfg_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
	end

	assign bucket    = req_q.key[lhrt_pkg::BUCKET_W-1:0];
	assign is_insert = (req_q.command == lhrt_pkg::CMD_INSERT);

	// occupied layers of a bucket always form a prefix, so a count per bucket
	// stands for the valid bits; a bucket row not marked valid holds no entry
	assign fill   = row_valid_q[bucket] ? cnt_rd_q : '0;
	assign full   = (fill == CW'(WAYS));
	assign ins_ok = cmd.commit && is_insert && !full;

	// bucket fill count memory
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cnt_rd_q <= cnt_mem[req.key[lhrt_pkg::BUCKET_W-1:0]];
		end
		if (ins_ok) begin
			cnt_mem[bucket] <= fill + CW'(1);
		end
	end

	// handle kept at the configured width
	assign hdl_ext  = 32'(req_q.handle);
	assign hdl_kept = 32'(hdl_ext[HANDLE_BITS-1:0]);

	// one key/handle bank per layer, all read at the bucket in parallel
	for (genvar w = 0; w < WAYS; w++) begin : g_bank
		logic [lhrt_pkg::KEY_W-1:0] key_mem [lhrt_pkg::BUCKETS];
		logic [HANDLE_BITS-1:0]     hdl_mem [lhrt_pkg::BUCKETS];

		always_ff @(posedge clk) begin
			if (cmd.accept) begin
				key_rd_q[w] <= key_mem[req.key[lhrt_pkg::BUCKET_W-1:0]];
				hdl_rd_q[w] <= hdl_mem[req.key[lhrt_pkg::BUCKET_W-1:0]];
			end
			if (ins_ok && (fill == CW'(w))) begin
				key_mem[bucket] <= req_q.key;
				hdl_mem[bucket] <= hdl_ext[HANDLE_BITS-1:0];
			end
		end
	end

	// key compare over the occupied layers
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = (CW'(w) < fill) && (key_rd_q[w] == req_q.key);
		end
	end

	// lowest matching layer wins
	always_comb begin
		hit_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_idx = LW'(w);
			end
		end
	end

	assign hit_any     = |match;
	assign hit_hdl     = 32'(hdl_rd_q[hit_idx]);
	assign fill_ext    = 32'(fill);
	assign hit_idx_ext = 32'(hit_idx);

	// layer count update: a new layer opens when an insert fits in a bucket that uses all layers in use; clear resets it
	always_comb begin
		layer_cnt_d = layer_cnt_q;
		if (is_insert && !full && (fill == layer_cnt_q)) begin
			layer_cnt_d = layer_cnt_q + CW'(1);
		end else if (req_q.command == lhrt_pkg::CMD_CLEAR) begin
			layer_cnt_d = '0;
		end
	end

	assign cnt_new_ext = 32'(layer_cnt_d);
	assign cnt_cur_ext = 32'(layer_cnt_q);

	// result
	always_comb begin
		rsp_d               = '0;
		rsp_d.layers_in_use = cnt_cur_ext[lhrt_pkg::LIU_W-1:0];
		case (req_q.command)
			lhrt_pkg::CMD_INSERT: begin
				rsp_d.layers_in_use = cnt_new_ext[lhrt_pkg::LIU_W-1:0];
				if (full) begin
					rsp_d.status = 1'b1;
				end else begin
					rsp_d.result_handle = hdl_kept[lhrt_pkg::HANDLE_W-1:0];
					rsp_d.layer         = fill_ext[lhrt_pkg::LAYER_W-1:0];
				end
			end
			lhrt_pkg::CMD_LOOKUP: begin
				if (hit_any) begin
					rsp_d.hit           = 1'b1;
					rsp_d.result_handle = hit_hdl[lhrt_pkg::HANDLE_W-1:0];
					rsp_d.layer         = hit_idx_ext[lhrt_pkg::LAYER_W-1:0];
				end else begin
					rsp_d.result_handle = fallback_q;
				end
			end
			lhrt_pkg::CMD_CLEAR: begin
				rsp_d.layers_in_use = '0;
			end
			default: begin
				rsp_d.layers_in_use = cnt_cur_ext[lhrt_pkg::LIU_W-1:0];
			end
		endcase
	end

	// table control state and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_cnt_q <= '0;
			row_valid_q <= '0;
		end else if (cmd.commit) begin
			layer_cnt_q <= layer_cnt_d;
			if (req_q.command == lhrt_pkg::CMD_CLEAR) begin
				row_valid_q <= '0;
			end else if (ins_ok) begin
				row_valid_q[bucket] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

`ifndef ASSERT_OFF
	// layer count never passes the number of layers
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		layer_cnt_q <= CW'(WAYS))
		else $error("layer count beyond layer total");

	// a bucket never holds more layers than are in use
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> fill <= layer_cnt_q)
		else $error("bucket fill above layers in use");

	// clear empties the whole table at once
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (req_q.command == lhrt_pkg::CMD_CLEAR)
		|=> (layer_cnt_q == '0) && (row_valid_q == '0))
		else $error("clear left state behind");

	// an insert that fits grows its bucket by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> row_valid_q[$past(bucket)]
			&& (cnt_mem[$past(bucket)] == $past(fill) + CW'(1)))
		else $error("insert did not grow bucket");
`endif

endmodule
